### hdl/assert_macros.svh
// Assertion macros for the radix-64 codec RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`define ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

### hdl/r64c_pkg.sv
// Types, codes and alphabet functions for the radix-64 codec.
// Used by r64c_engine, r64c_outq and radix64_codec.
package r64c_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;
    localparam logic [1:0] PH_3 = 2'd3;

    localparam logic [6:0] VAL_BAD = 7'd64;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       bad;
    } result_t;

    // up to two results produced by one request
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] sym_of(input logic [5:0] v);
        logic [7:0] s;
        if (v < 6'd26)
            s = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            s = 8'h61 + {2'b00, v} - 8'd26;
        else if (v < 6'd62)
            s = 8'h30 + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            s = 8'h2b;
        else
            s = 8'h2d;
        return s;
    endfunction

    // 0..63 for alphabet characters, VAL_BAD otherwise
    function automatic logic [6:0] val_of(input logic [7:0] c);
        logic [6:0] v;
        v = VAL_BAD;
        if (c >= 8'h41 && c <= 8'h5a)
            v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7a)
            v = 7'(c - 8'h61) + 7'd26;
        else if (c >= 8'h30 && c <= 8'h39)
            v = 7'(c - 8'h30) + 7'd52;
        else if (c == 8'h2b)
            v = 7'd62;
        else if (c == 8'h2d)
            v = 7'd63;
        return v;
    endfunction

endpackage

### hdl/radix64_codec.sv
// Path: a slave request is registered in the input item register, and its results in the result queue.
// Throughput: decode 1 character per cycle while the result queue has room; encode set by the
// master port at one result per cycle, the 4-entry result queue absorbs bursts.
// Reset (rst_n, async, active low): clears stream phase, residual, pending error,
// queue, and sets direction to encode.
module radix64_codec
    import r64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,       // direction
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_value
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_value
    output logic       m_axis_tlast,   // out_last
    output logic       m_axis_tuser    // [0] bad_char
);

    logic       dir_reg, dir_next;
    logic       item_valid_reg, item_valid_next;
    logic [7:0] item_value_reg;
    logic       item_last_reg;
    logic       room, fire, accept;
    push_t      push;

    assign cfg_ready       = 1'b1;
    assign dir_next        = (cfg_valid & cfg_ready) ? cfg_data : dir_reg;
    assign fire            = item_valid_reg & room;
    assign s_axis_tready   = ~item_valid_reg | room;
    assign accept          = s_axis_tvalid & s_axis_tready;
    assign item_valid_next = accept | (item_valid_reg & ~fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg        <= DIR_ENCODE;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg        <= dir_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_value_reg <= s_axis_tdata;
            item_last_reg  <= s_axis_tlast;
        end
    end

    r64c_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .direction (dir_reg),
        .in_value  (item_value_reg),
        .in_last   (item_last_reg),
        .push      (push)
    );

    r64c_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### hdl/r64c_engine.sv
// Codec step logic: phase, residual bits and pending error, one request per fire.
// Depends on r64c_pkg.
module r64c_engine
    import r64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       direction,
    input  logic [7:0] in_value,
    input  logic       in_last,
    output push_t      push
);

    logic [1:0] phase_reg, phase_next;
    logic [5:0] res_reg, res_next;
    logic       perr_reg, perr_next;

    logic [1:0] enc_ph;
    logic [6:0] raw;
    logic [5:0] v;
    logic       bad;
    logic [7:0] dec_byte;

    assign enc_ph = (phase_reg == PH_3) ? PH_0 : phase_reg;
    assign raw    = val_of(in_value);
    assign v      = raw[5:0];
    assign bad    = (raw == VAL_BAD) | perr_reg;

    always_comb
    begin
        case (phase_reg)
            PH_1:    dec_byte = {res_reg, v[5:4]};
            PH_2:    dec_byte = {res_reg[3:0], v[5:2]};
            default: dec_byte = {res_reg[1:0], v};
        endcase
    end

    always_comb
    begin
        push       = '0;
        phase_next = phase_reg;
        res_next   = res_reg;
        perr_next  = perr_reg;
        if (fire)
        begin
            if (direction == DIR_ENCODE)
            begin
                push.n = 2'd1;
                case (enc_ph)
                    PH_0:
                    begin
                        push.r0.value = sym_of(in_value[7:2]);
                        res_next      = {in_value[1:0], 4'b0000};
                        phase_next    = PH_1;
                    end
                    PH_1:
                    begin
                        push.r0.value = sym_of(res_reg | {2'b00, in_value[7:4]});
                        res_next      = {in_value[3:0], 2'b00};
                        phase_next    = PH_2;
                    end
                    default:
                    begin
                        push.r0.value = sym_of(res_reg | {4'b0000, in_value[7:6]});
                        push.r1.value = sym_of(in_value[5:0]);
                        push.r1.last  = in_last;
                        push.n        = 2'd2;
                        res_next      = '0;
                        phase_next    = PH_0;
                    end
                endcase
                if (in_last)
                begin
                    // flush partial group
                    if (phase_next != PH_0)
                    begin
                        push.r1.value = sym_of(res_next);
                        push.r1.last  = 1'b1;
                        push.n        = 2'd2;
                    end
                    phase_next = PH_0;
                    res_next   = '0;
                    perr_next  = 1'b0;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                res_next   = v;
                if (phase_reg == PH_0)
                    perr_next = bad;
                else
                begin
                    push.n        = 2'd1;
                    push.r0.value = dec_byte;
                    push.r0.last  = in_last;
                    push.r0.bad   = bad;
                    perr_next     = 1'b0;
                end
                if (in_last)
                begin
                    phase_next = PH_0;
                    res_next   = '0;
                    perr_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            res_reg   <= '0;
            perr_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            res_reg   <= res_next;
            perr_reg  <= perr_next;
        end
    end

endmodule

### hdl/r64c_outq.sv
// Result queue: takes up to two results per cycle, drives the master stream.
// Depends on r64c_pkg and assert_macros.svh.
`include "assert_macros.svh"

module r64c_outq
    import r64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_value
    output logic       m_axis_tlast,   // out_last
    output logic       m_axis_tuser    // [0] bad_char
);

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    result_t        mem [QDEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next, wptr_inc;
    logic [QCW-1:0] count_reg, count_next;
    logic           pop;
    result_t        head;

    assign wptr_inc      = wptr_reg + QAW'(1);
    assign head          = mem[rptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = head.value;
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = head.bad;
    assign pop           = m_axis_tvalid & m_axis_tready;
    assign room          = (count_reg <= QCW'(QDEPTH - 2));

    assign wptr_next  = wptr_reg + QAW'(push.n);
    assign rptr_next  = rptr_reg + QAW'(pop);
    assign count_next = count_reg + QCW'(push.n) - QCW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wptr_inc] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_q_overflow, clk, rst_n, count_reg > QCW'(QDEPTH))
    `ASSERT_IMPLY(a_q_push_room, clk, rst_n, push.n != 2'd0, room)
    `ASSERT_IMPLY(a_q_ptr_track, clk, rst_n, 1'b1, count_reg[QAW-1:0] == QAW'(wptr_reg - rptr_reg))

endmodule

### tb/tb_radix64_codec.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix64_codec: encodes and decodes streams in both directions.
// Keeps its own predictor of the codec state and checks every result in order.
// Depends on r64c_pkg and radix64_codec.
module tb_radix64_codec;
    import r64c_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
    } char_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
        logic       bad;
    } codec_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_value
    logic s_axis_tlast = 1'b0;          // last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_value
    logic m_axis_tlast;                 // out_last
    logic m_axis_tuser;                 // [0] bad_char

    radix64_codec u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    char_req_t  req_q[$];
    codec_out_t expected_outputs[$];

    // predictor state
    logic       mdl_dir = DIR_ENCODE;
    logic [1:0] mdl_phase = PH_0;
    logic [5:0] mdl_resid = 6'd0;
    logic       mdl_perr = 1'b0;

    int  queued_total = 0;
    int  accepted_total = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    int  quiet_cycles = 0;
    bit  idle_en = 1'b1;
    char_req_t  next_req;
    codec_out_t got;
    codec_out_t want;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s <= 6'd25)
            return 8'h41 + 8'(s);
        if (s <= 6'd51)
            return 8'h61 + 8'(s - 6'd26);
        if (s <= 6'd61)
            return 8'h30 + 8'(s - 6'd52);
        return (s == 6'd62) ? 8'h2b : 8'h2d;
    endfunction

    // {invalid, 6-bit value}; invalid characters count as zero
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
            return {1'b0, 6'(c - 8'h41)};
        if (c >= 8'h61 && c <= 8'h7a)
            return {1'b0, 6'(c - 8'h61 + 8'd26)};
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, 6'(c - 8'h30 + 8'd52)};
        if (c == 8'h2b)
            return {1'b0, 6'd62};
        if (c == 8'h2d)
            return {1'b0, 6'd63};
        return {1'b1, 6'd0};
    endfunction

    function automatic void push_out(input logic [7:0] v, input logic lst, input logic bad);
        codec_out_t o;
        o.value = v;
        o.is_last = lst;
        o.bad = bad;
        expected_outputs.push_back(o);
    endfunction

    function automatic void predict_codec_outputs(input logic [7:0] b, input logic lst);
        logic [6:0] dec;
        logic       bad;
        logic [7:0] byte_out;
        logic       emit;
        logic [1:0] ph;
        if (mdl_dir == DIR_ENCODE) begin
            ph = (mdl_phase == PH_3) ? PH_0 : mdl_phase;
            if (ph == PH_0) begin
                push_out(sextet_char(b[7:2]), 1'b0, 1'b0);
                mdl_resid = {b[1:0], 4'b0000};
                mdl_phase = PH_1;
            end else if (ph == PH_1) begin
                push_out(sextet_char(mdl_resid | {2'b00, b[7:4]}), 1'b0, 1'b0);
                mdl_resid = {b[3:0], 2'b00};
                mdl_phase = PH_2;
            end else begin
                push_out(sextet_char(mdl_resid | {4'b0000, b[7:6]}), 1'b0, 1'b0);
                push_out(sextet_char(b[5:0]), lst, 1'b0);
                mdl_resid = 6'd0;
                mdl_phase = PH_0;
            end
            if (lst) begin
                if (mdl_phase != PH_0)
                    push_out(sextet_char(mdl_resid), 1'b1, 1'b0);
                mdl_phase = PH_0;
                mdl_resid = 6'd0;
                mdl_perr = 1'b0;
            end
        end else begin
            dec = char_sextet(b);
            bad = dec[6] | mdl_perr;
            emit = 1'b1;
            byte_out = 8'h00;
            case (mdl_phase)
                PH_0:
                begin
                    emit = 1'b0;
                    mdl_phase = PH_1;
                end
                PH_1:
                begin
                    byte_out = {mdl_resid, dec[5:4]};
                    mdl_phase = PH_2;
                end
                PH_2:
                begin
                    byte_out = {mdl_resid[3:0], dec[5:2]};
                    mdl_phase = PH_3;
                end
                default:
                begin
                    byte_out = {mdl_resid[1:0], dec[5:0]};
                    mdl_phase = PH_0;
                end
            endcase
            mdl_resid = dec[5:0];
            if (emit) begin
                push_out(byte_out, lst, bad);
                mdl_perr = 1'b0;
            end else begin
                mdl_perr = bad;
            end
            if (lst) begin
                mdl_phase = PH_0;
                mdl_resid = 6'd0;
                mdl_perr = 1'b0;
            end
        end
    endfunction

    // mostly back-to-back, some short pauses, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_char(input logic [7:0] v, input logic lst);
        char_req_t q;
        q.value = v;
        q.is_last = lst;
        req_q.push_back(q);
        queued_total++;
    endfunction

    // random messages; the final one of a phase may be left open so the next
    // phase starts mid-group in the other direction
    task automatic queue_random_phase(input int count, input logic dir);
        int  sent;
        int  len;
        bit  tail_open;
        bit  final_msg;
        logic [7:0] v;
        sent = 0;
        tail_open = $urandom_range(0, 1);
        while (sent < count) begin
            len = $urandom_range(1, 12);
            final_msg = (sent + len >= count);
            for (int i = 0; i < len; i++) begin
                if (dir == DIR_ENCODE || $urandom_range(0, 99) >= 85)
                    v = 8'($urandom_range(0, 255));
                else
                    v = sextet_char(6'($urandom_range(0, 63)));
                queue_char(v, (i == len - 1) && !(final_msg && tail_open));
            end
            sent += len;
        end
    endtask

    task automatic drain();
        while (accepted_total != queued_total || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_dir = d;
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tlast <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_codec_outputs(s_axis_tdata, s_axis_tlast);
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    next_req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_req.value;
                    s_axis_tlast <= next_req.is_last;
                    gap_left = pick_pause();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.value = m_axis_tdata;
                got.is_last = m_axis_tlast;
                got.bad = m_axis_tuser;
                if (expected_outputs.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result value=%02h last=%b bad=%b",
                                 $time, got.value, got.is_last, got.bad);
                    mismatches++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch exp %02h/%b/%b got %02h/%b/%b",
                                     $time, want.value, want.is_last, want.bad,
                                     got.value, got.is_last, got.bad);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (holds_done < 2 && results_seen > 60 && req_q.size() > 20) begin
                // long hold-off while the sender keeps offering: fill up the block
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_pause();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode: full groups, one and two trailing bytes, top sextets
        set_direction(DIR_ENCODE);
        queue_char(8'h00, 1'b0);
        queue_char(8'hff, 1'b0);
        queue_char(8'h80, 1'b1);
        queue_char(8'h01, 1'b1);
        queue_char(8'hfc, 1'b0);
        queue_char(8'h03, 1'b1);
        queue_char(8'hff, 1'b1);
        drain();

        // decode: alphabet edges, invalid characters, lone trailing characters
        set_direction(DIR_DECODE);
        queue_char(8'h41, 1'b0);
        queue_char(8'h7a, 1'b0);
        queue_char(8'h2b, 1'b0);
        queue_char(8'h2d, 1'b1);
        queue_char(8'h00, 1'b0);
        queue_char(8'h5a, 1'b0);
        queue_char(8'h39, 1'b0);
        queue_char(8'hff, 1'b1);
        queue_char(8'h2f, 1'b0);
        queue_char(8'h3a, 1'b0);
        queue_char(8'h5b, 1'b0);
        queue_char(8'h60, 1'b0);
        queue_char(8'h7b, 1'b1);
        queue_char(8'h21, 1'b1);
        // left open at phase 3 so encode picks up there
        queue_char(8'h61, 1'b0);
        queue_char(8'h30, 1'b0);
        queue_char(8'h44, 1'b0);
        drain();

        for (int p = 0; p < 10; p++) begin
            idle_en = (p % 4 != 2);
            set_direction((p % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            queue_random_phase(55, (p % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
